// ===== design/sfpe_pkg.sv =====
// Package for the SPI flash program/erase sequencer.
// Holds item, result and group types, opcodes and group building helpers.
// No dependencies.
`default_nettype none

package sfpe_pkg;

  typedef enum logic [1:0] {
    ACT_ERASE  = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_DATA   = 2'd2,
    ACT_STATUS = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_SEND    = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_READ    = 2'd2,
    KIND_DONE    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_WEN_POLL   = 3'd1,
    PH_DATA       = 3'd2,
    PH_OP_POLL    = 3'd3,
    PH_CHUNK_BUSY = 3'd4,
    PH_CHUNK_WEL  = 3'd5,
    PH_PAIR_POLL  = 3'd6,
    PH_WDIS_POLL  = 3'd7
  } phase_t;

  typedef enum logic {
    REG_PROGRAM_MODE = 1'b0,
    REG_CHUNK_LOG2   = 1'b1
  } reg_index_t;

  localparam logic [7:0] OP_PAGE       = 8'h02;
  localparam logic [7:0] OP_ERASE_PAGE = 8'h20;
  localparam logic [7:0] OP_AAI        = 8'hAD;
  localparam logic [7:0] OP_ERASE_AAI  = 8'hD7;
  localparam logic [7:0] OP_WRDI       = 8'h04;
  localparam logic [7:0] OP_WREN       = 8'h06;
  localparam logic [7:0] OP_RDSR       = 8'h05;
  localparam logic [7:0] PAD_BYTE      = 8'hFF;

  localparam int unsigned MAX_RESULTS = 8;
  localparam logic [4:0]  CHUNK_LOG2_RESET = 5'd8;

  typedef struct packed {
    action_t     action;
    logic [23:0] address;
    logic [7:0]  data_byte;
    logic        last;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] spi_byte;
  } result_t;

  typedef struct packed {
    logic [3:0]                   count;
    result_t [MAX_RESULTS-1:0]    res;
  } group_t;

  function automatic group_t push(group_t g, kind_t k, logic [7:0] b);
    group_t r;
    r = g;
    r.res[g.count[2:0]].kind     = k;
    r.res[g.count[2:0]].spi_byte = (k == KIND_SEND) ? b : 8'h00;
    r.count = g.count + 4'd1;
    return r;
  endfunction

  function automatic group_t push_poll(group_t g);
    group_t r;
    r = push(g, KIND_SEND, OP_RDSR);
    r = push(r, KIND_READ, 8'h00);
    r = push(r, KIND_RELEASE, 8'h00);
    return r;
  endfunction

  function automatic group_t push_addr(group_t g, logic [23:0] a);
    group_t r;
    r = push(g, KIND_SEND, a[23:16]);
    r = push(r, KIND_SEND, a[15:8]);
    r = push(r, KIND_SEND, a[7:0]);
    return r;
  endfunction

  // boundary when the low chunk_log2 bits of the address are all zero
  function automatic logic chunk_boundary(logic [23:0] a, logic [4:0] log2);
    logic [23:0] mask;
    for (int i = 0; i < 24; i++) begin
      mask[i] = (5'(i) < log2);
    end
    return (a & mask) == 24'h0;
  endfunction

endpackage

`default_nettype wire

// ===== design/sfpe_if.sv =====
// Valid/ready channel interfaces for the sequencer: request items,
// result items and configuration writes. Depends on sfpe_pkg.
`default_nettype none

interface sfpe_req_if;
  logic                 valid;
  logic                 ready;
  sfpe_pkg::action_t    action;
  logic [23:0]          address;
  logic [7:0]           data_byte;
  logic                 last;
  modport source (output valid, action, address, data_byte, last, input ready);
  modport sink   (input valid, action, address, data_byte, last, output ready);
endinterface

interface sfpe_rsp_if;
  logic               valid;
  logic               ready;
  sfpe_pkg::kind_t    kind;
  logic [7:0]         spi_byte;
  logic               run_end;
  modport source (output valid, kind, spi_byte, run_end, input ready);
  modport sink   (input valid, kind, spi_byte, run_end, output ready);
endinterface

interface sfpe_cfg_if;
  logic                  valid;
  logic                  ready;
  sfpe_pkg::reg_index_t  index;
  logic [4:0]            data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/sfpe_seq.sv =====
// Sequencer state and per-item group builder: from the registered item and
// the current phase, forms all results of that item. Depends on sfpe_pkg.
`default_nettype none

module sfpe_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire sfpe_pkg::item_t item,
  input  wire logic            program_mode,
  input  wire logic [4:0]      chunk_log2,
  output sfpe_pkg::group_t     grp
);

  sfpe_pkg::phase_t phase, phase_next;
  logic [23:0]      cur_address, cur_address_next;
  logic             is_erase, is_erase_next;
  logic             pair_half, pair_half_next;
  logic             final_seen, final_seen_next;

  logic        is_begin, is_data, is_status;
  logic        wel_ok, idle_ok, wdis_ok;
  logic [23:0] addr_inc;
  logic        boundary;

  assign is_begin  = (item.action == sfpe_pkg::ACT_ERASE) ||
                     (item.action == sfpe_pkg::ACT_WRITE);
  assign is_data   = (item.action == sfpe_pkg::ACT_DATA);
  assign is_status = (item.action == sfpe_pkg::ACT_STATUS);
  assign wel_ok    = (item.data_byte[1:0] == 2'b10);
  assign idle_ok   = !item.data_byte[0];
  assign wdis_ok   = (item.data_byte[1:0] == 2'b00);
  assign addr_inc  = cur_address + 24'd1;
  assign boundary  = sfpe_pkg::chunk_boundary(addr_inc, chunk_log2);

  always_comb begin
    phase_next       = phase;
    cur_address_next = cur_address;
    is_erase_next    = is_erase;
    pair_half_next   = pair_half;
    final_seen_next  = final_seen;
    unique case (phase)
      sfpe_pkg::PH_IDLE: begin
        if (is_begin) begin
          phase_next       = sfpe_pkg::PH_WEN_POLL;
          is_erase_next    = (item.action == sfpe_pkg::ACT_ERASE);
          cur_address_next = item.address;
          pair_half_next   = 1'b0;
          final_seen_next  = 1'b0;
        end
      end
      sfpe_pkg::PH_WEN_POLL: begin
        if (is_status && wel_ok) begin
          phase_next = is_erase ? sfpe_pkg::PH_OP_POLL : sfpe_pkg::PH_DATA;
        end
      end
      sfpe_pkg::PH_DATA: begin
        if (is_data) begin
          cur_address_next = addr_inc;
          if (!program_mode) begin
            if (item.last) begin
              final_seen_next = 1'b1;
              phase_next      = sfpe_pkg::PH_OP_POLL;
            end else if (boundary) begin
              phase_next = sfpe_pkg::PH_CHUNK_BUSY;
            end
          end else if (!pair_half && !item.last) begin
            pair_half_next = 1'b1;
          end else begin
            if (!pair_half) begin
              cur_address_next = addr_inc + 24'd1;
            end
            pair_half_next = 1'b0;
            if (item.last) begin
              final_seen_next = 1'b1;
            end
            phase_next = sfpe_pkg::PH_PAIR_POLL;
          end
        end
      end
      sfpe_pkg::PH_OP_POLL: begin
        if (is_status && idle_ok) phase_next = sfpe_pkg::PH_WDIS_POLL;
      end
      sfpe_pkg::PH_CHUNK_BUSY: begin
        if (is_status && idle_ok) phase_next = sfpe_pkg::PH_CHUNK_WEL;
      end
      sfpe_pkg::PH_CHUNK_WEL: begin
        if (is_status && wel_ok) phase_next = sfpe_pkg::PH_DATA;
      end
      sfpe_pkg::PH_PAIR_POLL: begin
        if (is_status && idle_ok) begin
          phase_next = final_seen ? sfpe_pkg::PH_WDIS_POLL : sfpe_pkg::PH_DATA;
        end
      end
      sfpe_pkg::PH_WDIS_POLL: begin
        if (is_status && wdis_ok) begin
          phase_next      = sfpe_pkg::PH_IDLE;
          final_seen_next = 1'b0;
          pair_half_next  = 1'b0;
        end
      end
      default: phase_next = phase;
    endcase
  end

  always_comb begin
    grp = '0;
    unique case (phase)
      sfpe_pkg::PH_IDLE: begin
        if (is_begin) begin
          grp = sfpe_pkg::push(grp, sfpe_pkg::KIND_SEND, sfpe_pkg::OP_WREN);
          grp = sfpe_pkg::push(grp, sfpe_pkg::KIND_RELEASE, 8'h00);
          grp = sfpe_pkg::push_poll(grp);
        end
      end
      sfpe_pkg::PH_WEN_POLL: begin
        if (is_status) begin
          if (!wel_ok) begin
            grp = sfpe_pkg::push_poll(grp);
          end else if (is_erase) begin
            grp = sfpe_pkg::push(grp, sfpe_pkg::KIND_SEND, program_mode ?
                                 sfpe_pkg::OP_ERASE_AAI : sfpe_pkg::OP_ERASE_PAGE);
            grp = sfpe_pkg::push_addr(grp, cur_address);
            grp = sfpe_pkg::push(grp, sfpe_pkg::KIND_RELEASE, 8'h00);
            grp = sfpe_pkg::push_poll(grp);
          end else begin
            grp = sfpe_pkg::push(grp, sfpe_pkg::KIND_SEND, program_mode ?
                                 sfpe_pkg::OP_AAI : sfpe_pkg::OP_PAGE);
            grp = sfpe_pkg::push_addr(grp, cur_address);
          end
        end
      end
      sfpe_pkg::PH_DATA: begin
        if (is_data) begin
          grp = sfpe_pkg::push(grp, sfpe_pkg::KIND_SEND, item.data_byte);
          if (!program_mode) begin
            if (item.last || boundary) begin
              grp = sfpe_pkg::push(grp, sfpe_pkg::KIND_RELEASE, 8'h00);
              grp = sfpe_pkg::push_poll(grp);
            end
          end else if (pair_half || item.last) begin
            if (!pair_half) begin
              grp = sfpe_pkg::push(grp, sfpe_pkg::KIND_SEND, sfpe_pkg::PAD_BYTE);
            end
            grp = sfpe_pkg::push(grp, sfpe_pkg::KIND_RELEASE, 8'h00);
            grp = sfpe_pkg::push_poll(grp);
          end
        end
      end
      sfpe_pkg::PH_OP_POLL: begin
        if (is_status) begin
          if (!idle_ok) begin
            grp = sfpe_pkg::push_poll(grp);
          end else begin
            grp = sfpe_pkg::push(grp, sfpe_pkg::KIND_SEND, sfpe_pkg::OP_WRDI);
            grp = sfpe_pkg::push(grp, sfpe_pkg::KIND_RELEASE, 8'h00);
            grp = sfpe_pkg::push_poll(grp);
          end
        end
      end
      sfpe_pkg::PH_CHUNK_BUSY: begin
        if (is_status) begin
          if (idle_ok) begin
            grp = sfpe_pkg::push(grp, sfpe_pkg::KIND_SEND, sfpe_pkg::OP_WREN);
            grp = sfpe_pkg::push(grp, sfpe_pkg::KIND_RELEASE, 8'h00);
          end
          grp = sfpe_pkg::push_poll(grp);
        end
      end
      sfpe_pkg::PH_CHUNK_WEL: begin
        if (is_status) begin
          if (!wel_ok) begin
            grp = sfpe_pkg::push_poll(grp);
          end else begin
            grp = sfpe_pkg::push(grp, sfpe_pkg::KIND_SEND, sfpe_pkg::OP_PAGE);
            grp = sfpe_pkg::push_addr(grp, cur_address);
          end
        end
      end
      sfpe_pkg::PH_PAIR_POLL: begin
        if (is_status) begin
          if (!idle_ok) begin
            grp = sfpe_pkg::push_poll(grp);
          end else if (final_seen) begin
            grp = sfpe_pkg::push(grp, sfpe_pkg::KIND_SEND, sfpe_pkg::OP_WRDI);
            grp = sfpe_pkg::push(grp, sfpe_pkg::KIND_RELEASE, 8'h00);
            grp = sfpe_pkg::push_poll(grp);
          end else begin
            grp = sfpe_pkg::push(grp, sfpe_pkg::KIND_SEND, sfpe_pkg::OP_AAI);
          end
        end
      end
      sfpe_pkg::PH_WDIS_POLL: begin
        if (is_status) begin
          if (!wdis_ok) begin
            grp = sfpe_pkg::push_poll(grp);
          end else begin
            grp = sfpe_pkg::push(grp, sfpe_pkg::KIND_DONE, 8'h00);
          end
        end
      end
      default: grp = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= sfpe_pkg::PH_IDLE;
      cur_address <= '0;
      is_erase    <= 1'b0;
      pair_half   <= 1'b0;
      final_seen  <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      cur_address <= cur_address_next;
      is_erase    <= is_erase_next;
      pair_half   <= pair_half_next;
      final_seen  <= final_seen_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/spi_flash_program_erase_sequencer_top.sv =====
// Top level of the SPI NOR flash program/erase sequencer: configuration
// registers, input register, result group buffer and result emitter.
// Depends on sfpe_pkg, sfpe_if and sfpe_seq.
//
// Items are taken into an input register one per cycle unless the pending
// group register is still full; the sequencer turns each item into a group
// of zero to eight results (eight for a sector erase command) and parks it
// in a pending group register while the previous group is shifted out.
// Results leave on the rsp port one per cycle while rsp.ready is high. The
// single result port limits the flow of items.
// Configuration writes are always taken (ready tied high).
`default_nettype none

module spi_flash_program_erase_sequencer_top (
  input wire logic   clk,
  input wire logic   rst,
  sfpe_req_if.sink   req,
  sfpe_rsp_if.source rsp,
  sfpe_cfg_if.sink   cfg
);

  logic       program_mode;
  logic [4:0] chunk_log2;

  logic            in_valid;
  sfpe_pkg::item_t in_item;
  logic            advance;

  sfpe_pkg::group_t grp;
  sfpe_pkg::group_t pend;
  logic             pend_valid;
  logic             pend_move;

  sfpe_pkg::group_t cur;
  logic             cur_valid;
  logic [2:0]       cur_idx;
  logic             rsp_take;
  logic             cur_done;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_mode <= 1'b0;
      chunk_log2   <= sfpe_pkg::CHUNK_LOG2_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        sfpe_pkg::REG_PROGRAM_MODE: program_mode <= cfg.data[0];
        sfpe_pkg::REG_CHUNK_LOG2:   chunk_log2   <= cfg.data;
        default:                    program_mode <= program_mode;
      endcase
    end
  end

  assign rsp_take  = rsp.valid && rsp.ready;
  assign cur_done  = rsp_take && ({1'b0, cur_idx} == cur.count - 4'd1);
  assign pend_move = pend_valid && (!cur_valid || cur_done);
  assign advance   = in_valid && (!pend_valid || pend_move);
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item <= '{action: req.action, address: req.address,
                   data_byte: req.data_byte, last: req.last};
    end
  end

  sfpe_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .item         (in_item),
    .program_mode (program_mode),
    .chunk_log2   (chunk_log2),
    .grp          (grp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (advance && (grp.count != 4'd0)) begin
      pend_valid <= 1'b1;
    end else if (pend_move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (grp.count != 4'd0)) begin
      pend <= grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_idx   <= '0;
    end else if (pend_move) begin
      cur_valid <= 1'b1;
      cur_idx   <= '0;
    end else if (cur_done) begin
      cur_valid <= 1'b0;
    end else if (rsp_take) begin
      cur_idx <= cur_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      cur <= pend;
    end
  end

  assign rsp.valid    = cur_valid;
  assign rsp.kind     = cur.res[cur_idx].kind;
  assign rsp.spi_byte = cur.res[cur_idx].spi_byte;
  assign rsp.run_end  = ({1'b0, cur_idx} == cur.count - 4'd1);

  a_idx_in_group: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> ({1'b0, cur_idx} < cur.count))
    else $error("result index beyond group");

  a_group_nonempty: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.count != 4'd0))
    else $error("empty group in emitter");

  a_pend_drains: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !cur_valid) |=> cur_valid)
    else $error("pending group not moved to emitter");

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.kind == sfpe_pkg::KIND_DONE)) |-> rsp.run_end)
    else $error("done result not last of its item");

endmodule

`default_nettype wire

// ===== sim/spi_command_scoreboard_pkg.sv =====
// Scoreboard for the SPI flash program/erase sequencer: tracks the command
// sequence state and holds the SPI results still to come. Depends on sfpe_pkg.
`timescale 1ns / 1ps

package spi_command_scoreboard_pkg;
  import sfpe_pkg::*;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] spi_byte;
    logic       run_end;
  } spi_cmd_t;

  class spi_command_scoreboard;
    phase_t      ph;
    logic [23:0] addr;
    bit          erase_op;
    bit          half;
    bit          last_taken;
    bit          aai_mode;
    logic [4:0]  log2;

    spi_cmd_t    pending_cmds[$];
    spi_cmd_t    new_cmds[$];
    int          mismatches;
    int          checked;

    function new();
      ph         = PH_IDLE;
      addr       = '0;
      erase_op   = 1'b0;
      half       = 1'b0;
      last_taken = 1'b0;
      aai_mode   = 1'b0;
      log2       = CHUNK_LOG2_RESET;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [4:0] val);
      if (idx == REG_PROGRAM_MODE) begin
        aai_mode = val[0];
      end else begin
        log2 = val;
      end
    endfunction

    function logic [23:0] chunk_mask();
      logic [24:0] m;
      int unsigned sh;
      sh = (log2 > 5'd24) ? 24 : int'(log2);
      m  = (25'd1 << sh) - 25'd1;
      return m[23:0];
    endfunction

    function int pending();
      return pending_cmds.size();
    endfunction

    function void put(kind_t k, logic [7:0] b);
      spi_cmd_t c;
      c.kind     = k;
      c.spi_byte = (k == KIND_SEND) ? b : 8'h00;
      c.run_end  = 1'b0;
      new_cmds.push_back(c);
    endfunction

    function void poll_status();
      put(KIND_SEND, OP_RDSR);
      put(KIND_READ, 8'h00);
      put(KIND_RELEASE, 8'h00);
    endfunction

    function void send_addr();
      put(KIND_SEND, addr[23:16]);
      put(KIND_SEND, addr[15:8]);
      put(KIND_SEND, addr[7:0]);
    endfunction

    function void begin_wen();
      put(KIND_SEND, OP_WREN);
      put(KIND_RELEASE, 8'h00);
      poll_status();
    endfunction

    function void begin_wdis();
      put(KIND_SEND, OP_WRDI);
      put(KIND_RELEASE, 8'h00);
      poll_status();
      ph = PH_WDIS_POLL;
    endfunction

    function void take_status(logic [7:0] s);
      bit wel_ok;
      bit idle_ok;
      wel_ok  = (s[1:0] == 2'b10);
      idle_ok = !s[0];
      case (ph)
        PH_WEN_POLL: begin
          if (!wel_ok) begin
            poll_status();
          end else if (erase_op) begin
            put(KIND_SEND, aai_mode ? OP_ERASE_AAI : OP_ERASE_PAGE);
            send_addr();
            put(KIND_RELEASE, 8'h00);
            poll_status();
            ph = PH_OP_POLL;
          end else begin
            put(KIND_SEND, aai_mode ? OP_AAI : OP_PAGE);
            send_addr();
            ph = PH_DATA;
          end
        end
        PH_OP_POLL: begin
          if (!idle_ok) poll_status();
          else begin_wdis();
        end
        PH_CHUNK_BUSY: begin
          if (!idle_ok) begin
            poll_status();
          end else begin
            begin_wen();
            ph = PH_CHUNK_WEL;
          end
        end
        PH_CHUNK_WEL: begin
          if (!wel_ok) begin
            poll_status();
          end else begin
            put(KIND_SEND, OP_PAGE);
            send_addr();
            ph = PH_DATA;
          end
        end
        PH_PAIR_POLL: begin
          if (!idle_ok) begin
            poll_status();
          end else if (last_taken) begin
            begin_wdis();
          end else begin
            put(KIND_SEND, OP_AAI);
            ph = PH_DATA;
          end
        end
        PH_WDIS_POLL: begin
          if (s[1:0] != 2'b00) begin
            poll_status();
          end else begin
            put(KIND_DONE, 8'h00);
            last_taken = 1'b0;
            half       = 1'b0;
            ph         = PH_IDLE;
          end
        end
        default: ;
      endcase
    endfunction

    function void take_data(logic [7:0] b, logic l);
      put(KIND_SEND, b);
      addr = addr + 24'd1;
      if (!aai_mode) begin
        if (l) begin
          last_taken = 1'b1;
          put(KIND_RELEASE, 8'h00);
          poll_status();
          ph = PH_OP_POLL;
        end else if ((addr & chunk_mask()) == 24'h0) begin
          put(KIND_RELEASE, 8'h00);
          poll_status();
          ph = PH_CHUNK_BUSY;
        end
        return;
      end
      if (!half && !l) begin
        half = 1'b1;
        return;
      end
      // odd length: pad the second byte of the pair
      if (!half) begin
        put(KIND_SEND, PAD_BYTE);
        addr = addr + 24'd1;
      end
      half = 1'b0;
      if (l) last_taken = 1'b1;
      put(KIND_RELEASE, 8'h00);
      poll_status();
      ph = PH_PAIR_POLL;
    endfunction

    // returns the number of results the item causes
    function int note(item_t it);
      new_cmds.delete();
      case (it.action)
        ACT_ERASE, ACT_WRITE: begin
          if (ph == PH_IDLE) begin
            erase_op   = (it.action == ACT_ERASE);
            addr       = it.address;
            half       = 1'b0;
            last_taken = 1'b0;
            begin_wen();
            ph = PH_WEN_POLL;
          end
        end
        ACT_DATA: begin
          if (ph == PH_DATA) take_data(it.data_byte, it.last);
        end
        default: take_status(it.data_byte);
      endcase
      if (new_cmds.size() > 0) new_cmds[new_cmds.size()-1].run_end = 1'b1;
      foreach (new_cmds[i]) pending_cmds.push_back(new_cmds[i]);
      return new_cmds.size();
    endfunction

    function void report(string what, spi_cmd_t want, kind_t k, logic [7:0] b, logic e);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s at result %0d: expected kind %0d byte %h end %b, got kind %0d byte %h end %b",
                 what, checked, want.kind, want.spi_byte, want.run_end, k, b, e);
      end
    endfunction

    function void check(kind_t k, logic [7:0] b, logic e);
      spi_cmd_t want;
      want = '0;
      checked++;
      if (pending_cmds.size() == 0) begin
        report("unexpected result", want, k, b, e);
        return;
      end
      want = pending_cmds.pop_front();
      if (want.kind !== k || want.spi_byte !== b || want.run_end !== e) begin
        report("mismatch", want, k, b, e);
      end
    endfunction
  endclass

endpackage

// ===== sim/spi_flash_program_erase_sequencer_top_test.sv =====
// Testbench for spi_flash_program_erase_sequencer_top: acts as host and flash,
// checks every SPI result item. Depends on sfpe_pkg, sfpe_if and the scoreboard.
`timescale 1ns / 1ps

module spi_flash_program_erase_sequencer_top_test;
  import sfpe_pkg::*;
  import spi_command_scoreboard_pkg::*;

  localparam int PHASE_ITEMS    = 50;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk;
  logic rst;

  sfpe_req_if req();
  sfpe_rsp_if rsp();
  sfpe_cfg_if cfg();

  spi_flash_program_erase_sequencer_top dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  spi_command_scoreboard sb;
  bit quiet;
  int send_calm;
  int items_sent;
  int items_with_results;
  int settings_run;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic item_t mk(action_t a, logic [23:0] ad, logic [7:0] b, logic l);
    item_t it;
    it.action    = a;
    it.address   = ad;
    it.data_byte = b;
    it.last      = l;
    return it;
  endfunction

  // next item from the flash/host point of view; closing steers to idle
  function automatic item_t pick_item(bit closing);
    item_t it;
    logic [23:0] mask;
    int r;
    it.action    = action_t'($urandom_range(0, 3));
    it.address   = 24'($urandom);
    it.data_byte = 8'($urandom);
    it.last      = 1'($urandom);
    if (!closing && $urandom_range(0, 99) < 8) return it;
    case (sb.ph)
      PH_IDLE: begin
        it.action = ($urandom_range(0, 2) == 0) ? ACT_ERASE : ACT_WRITE;
        mask = sb.chunk_mask();
        r = $urandom_range(0, 9);
        if (r >= 3 && r < 7) begin
          it.address = (it.address | mask) - 24'($urandom_range(0, 3));
        end else if (r == 7) begin
          it.address = 24'hFFFFFF - 24'($urandom_range(0, 3));
        end else if (r == 8) begin
          it.address = 24'h000000;
        end
      end
      PH_DATA: begin
        it.action = ACT_DATA;
        it.last   = closing || ($urandom_range(0, 4) == 0);
      end
      default: begin
        it.action = ACT_STATUS;
        if (closing || $urandom_range(0, 3) != 0) begin
          case (sb.ph)
            PH_WEN_POLL, PH_CHUNK_WEL: it.data_byte[1:0] = 2'b10;
            PH_WDIS_POLL:              it.data_byte[1:0] = 2'b00;
            default:                   it.data_byte[0]   = 1'b0;
          endcase
        end
      end
    endcase
    return it;
  endfunction

  task automatic send_item(item_t it);
    if (send_calm > 0) begin
      send_calm--;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end else if ($urandom_range(0, 29) == 0) begin
      send_calm = $urandom_range(20, 60);
    end
    req.valid     <= 1'b1;
    req.action    <= it.action;
    req.address   <= it.address;
    req.data_byte <= it.data_byte;
    req.last      <= it.last;
    do @(posedge clk); while (!(req.valid && req.ready));
    items_sent++;
    if (sb.note(it) > 0) items_with_results++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(bit mode, logic [4:0] log2);
    cfg.valid <= 1'b1;
    cfg.index <= REG_PROGRAM_MODE;
    cfg.data  <= {4'b0, mode};
    do @(posedge clk); while (!(cfg.valid && cfg.ready));
    sb.set_reg(REG_PROGRAM_MODE, {4'b0, mode});
    cfg.index <= REG_CHUNK_LOG2;
    cfg.data  <= log2;
    do @(posedge clk); while (!(cfg.valid && cfg.ready));
    sb.set_reg(REG_CHUNK_LOG2, log2);
    cfg.valid <= 1'b0;
    settings_run++;
  endtask

  task automatic run_setting(bit mode, logic [4:0] log2);
    int target;
    set_config(mode, log2);
    target = items_with_results + PHASE_ITEMS;
    while (items_with_results < target) send_item(pick_item(1'b0));
    while (sb.ph != PH_IDLE) send_item(pick_item(1'b1));
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) sb.check(rsp.kind, rsp.spi_byte, rsp.run_end);
  end

  initial begin
    int calm;
    calm = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (quiet || calm > 0) begin
        rsp.ready <= 1'b1;
        if (calm > 0) calm--;
      end else if ($urandom_range(0, 4) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= 1'b1;
        if ($urandom_range(0, 29) == 0) calm = $urandom_range(20, 60);
      end
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (cfg.valid && cfg.ready)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, sb.pending());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    bit         modes[8];
    logic [4:0] sizes[8];
    modes = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    sizes = '{5'd8, 5'd0, 5'd0, 5'd16, 5'd16, 5'd3, 5'd5, 5'd1};
    sb = new();
    quiet = 1'b0;
    send_calm = 0;
    items_sent = 0;
    items_with_results = 0;
    settings_run = 0;
    req.valid     <= 1'b0;
    req.action    <= ACT_ERASE;
    req.address   <= 24'h0;
    req.data_byte <= 8'h00;
    req.last      <= 1'b0;
    cfg.valid     <= 1'b0;
    cfg.index     <= REG_PROGRAM_MODE;
    cfg.data      <= 5'd0;
    rst           <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: page mode, 256-byte chunks
    send_item(mk(ACT_DATA,   24'h000000, 8'hFF, 1'b1));
    send_item(mk(ACT_STATUS, 24'hFFFFFF, 8'hFF, 1'b0));
    send_item(mk(ACT_ERASE,  24'hFFFFFF, 8'h00, 1'b0));
    send_item(mk(ACT_WRITE,  24'h000000, 8'h00, 1'b1));
    send_item(mk(ACT_STATUS, 24'h000000, 8'h01, 1'b0));
    send_item(mk(ACT_STATUS, 24'h000000, 8'h02, 1'b0));
    send_item(mk(ACT_DATA,   24'h000000, 8'h55, 1'b0));
    send_item(mk(ACT_STATUS, 24'h000000, 8'h03, 1'b0));
    send_item(mk(ACT_STATUS, 24'h000000, 8'h02, 1'b0));
    send_item(mk(ACT_STATUS, 24'h000000, 8'h02, 1'b0));
    send_item(mk(ACT_STATUS, 24'h000000, 8'hFC, 1'b0));
    send_item(mk(ACT_WRITE,  24'h0000FE, 8'h00, 1'b0));
    send_item(mk(ACT_STATUS, 24'h000000, 8'hFE, 1'b0));
    send_item(mk(ACT_DATA,   24'h000000, 8'h00, 1'b0));
    send_item(mk(ACT_DATA,   24'h000000, 8'hFF, 1'b0));
    send_item(mk(ACT_STATUS, 24'h000000, 8'hFE, 1'b0));
    send_item(mk(ACT_STATUS, 24'h000000, 8'h02, 1'b0));
    send_item(mk(ACT_DATA,   24'h000000, 8'hA5, 1'b1));
    send_item(mk(ACT_STATUS, 24'h000000, 8'h00, 1'b0));
    send_item(mk(ACT_STATUS, 24'h000000, 8'h00, 1'b0));
    drain();

    // AAI with an odd byte count across the top of the address space
    set_config(1'b1, 5'd0);
    send_item(mk(ACT_WRITE,  24'hFFFFFF, 8'h00, 1'b0));
    send_item(mk(ACT_STATUS, 24'h000000, 8'h02, 1'b0));
    send_item(mk(ACT_DATA,   24'h000000, 8'h5A, 1'b1));
    send_item(mk(ACT_STATUS, 24'h000000, 8'h00, 1'b0));
    send_item(mk(ACT_STATUS, 24'h000000, 8'h00, 1'b0));
    drain();

    for (int i = 0; i < 8; i++) begin
      if (i == 7) quiet = 1'b1;
      run_setting(modes[i], sizes[i]);
    end

    $display("sent %0d items (%0d producing SPI traffic) over %0d register settings",
             items_sent, items_with_results, settings_run);
    $display("checked %0d result items, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
